/* rtl/bfscp_pkg.sv */
// Shared constants and types of the chart path finder.
`timescale 1ns / 1ps

package bfscp_pkg;

  localparam int CHART_W        = 6;
  localparam int CNT_W          = 2;
  localparam int MAX_NEIGHBOURS = 3;
  localparam int MAX_CHARTS_DEF = 64;
  localparam int PRED_W         = CHART_W + 1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]                           cnt;
    logic [MAX_NEIGHBOURS-1:0][CHART_W-1:0]     nbr;
  } row_t;

  typedef struct packed {
    logic load_row;
    logic take_query;
    logic q_init;
    logic pop_rd;
    logic pop_take;
    logic nbr_step;
    logic tr_start;
    logic tr_next;
    logic emit_path;
    logic emit_nf;
  } cmd_t;

  typedef struct packed {
    logic bad_query;
    logic q_empty;
    logic cur_is_src;
    logic nbr_done;
    logic pred_end;
    logic out_free;
  } sts_t;

endpackage

/* rtl/bfscp_in_if.sv */
// Request channel: adjacency loads and path queries.
`timescale 1ns / 1ps

interface bfscp_in_if;
  import bfscp_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [CHART_W-1:0] row_chart;
  logic [CNT_W-1:0]   nbr_count;
  logic [CHART_W-1:0] nbr_first;
  logic [CHART_W-1:0] nbr_second;
  logic [CHART_W-1:0] nbr_third;
  logic [CHART_W-1:0] source_chart;
  logic [CHART_W-1:0] target_chart;

  modport source (
    output valid, mode, row_chart, nbr_count, nbr_first, nbr_second, nbr_third,
           source_chart, target_chart,
    input  ready
  );

  modport sink (
    input  valid, mode, row_chart, nbr_count, nbr_first, nbr_second, nbr_third,
           source_chart, target_chart,
    output ready
  );
endinterface

/* rtl/bfscp_out_if.sv */
// Result channel: path charts in order, source first.
`timescale 1ns / 1ps

interface bfscp_out_if;
  import bfscp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHART_W-1:0] path_chart;
  logic               found;
  logic               last;

  modport source (
    output valid, path_chart, found, last,
    input  ready
  );

  modport sink (
    input  valid, path_chart, found, last,
    output ready
  );
endinterface

/* rtl/bfs_chart_path_finder.sv */
// Top level of the breadth-first chart path finder.
//
//   channel  | dir | carries
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | mode, row_chart, nbr_count, nbr_first..third, source/target
//   out_ch   | out | path_chart, found, last
//
// A load is taken straight from idle. A query sets up the search queue, then for each
// dequeued chart reads its adjacency row and steps through its listed neighbors, then
// walks the predecessor table to emit the path; the sequencer is single-issue.
// Neighbor counts reset through per-row valid flops; no clearing pass.
// A stalled out_ch holds the path walk; in_ch is ready whenever the block is idle.
`timescale 1ns / 1ps

module bfs_chart_path_finder #(
  parameter int MAX_CHARTS = bfscp_pkg::MAX_CHARTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  bfscp_in_if.sink   in_ch,
  bfscp_out_if.source out_ch
);
  import bfscp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfscp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bfscp_datapath #(
    .MAX_CHARTS (MAX_CHARTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_row_chart    (in_ch.row_chart),
    .in_nbr_count    (in_ch.nbr_count),
    .in_nbr_first    (in_ch.nbr_first),
    .in_nbr_second   (in_ch.nbr_second),
    .in_nbr_third    (in_ch.nbr_third),
    .in_source_chart (in_ch.source_chart),
    .in_target_chart (in_ch.target_chart),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_path_chart  (out_ch.path_chart),
    .out_found       (out_ch.found),
    .out_last        (out_ch.last)
  );

endmodule

/* rtl/bfscp_datapath.sv */
// Adjacency table, search queue, predecessor table and result register.
`timescale 1ns / 1ps

module bfscp_datapath #(
  parameter int MAX_CHARTS = bfscp_pkg::MAX_CHARTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bfscp_pkg::cmd_t           cmd,
  output bfscp_pkg::sts_t           sts,
  input  logic [bfscp_pkg::CHART_W-1:0] in_row_chart,
  input  logic [bfscp_pkg::CNT_W-1:0]   in_nbr_count,
  input  logic [bfscp_pkg::CHART_W-1:0] in_nbr_first,
  input  logic [bfscp_pkg::CHART_W-1:0] in_nbr_second,
  input  logic [bfscp_pkg::CHART_W-1:0] in_nbr_third,
  input  logic [bfscp_pkg::CHART_W-1:0] in_source_chart,
  input  logic [bfscp_pkg::CHART_W-1:0] in_target_chart,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [bfscp_pkg::CHART_W-1:0] out_path_chart,
  output logic                      out_found,
  output logic                      out_last
);
  import bfscp_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHARTS);
  localparam logic [CHART_W:0] LIMIT = (CHART_W + 1)'(MAX_CHARTS);

  row_t                 row_mem_r   [MAX_CHARTS];
  logic [CHART_W-1:0]   queue_mem_r [MAX_CHARTS];
  logic [PRED_W-1:0]    pred_mem_r  [MAX_CHARTS];

  logic [MAX_CHARTS-1:0] row_vld_r;
  logic [MAX_CHARTS-1:0] visited_r;
  logic [IDX_W:0]        head_r;
  logic [IDX_W:0]        tail_r;

  logic [CHART_W-1:0]   src_r;
  logic [CHART_W-1:0]   tgt_r;
  logic [CHART_W-1:0]   cur_r;
  logic [CHART_W-1:0]   qdata_r;
  row_t                 row_r;
  logic                 rdvld_r;
  logic [CNT_W-1:0]     k_r;
  logic [PRED_W-1:0]    pred_rd_r;

  logic                 out_valid_r;
  logic [CHART_W-1:0]   path_r;
  logic                 found_r;
  logic                 last_r;

  logic                 row_ok;
  logic [CNT_W-1:0]     cnt_eff;
  logic [CHART_W-1:0]   nb;
  logic                 nb_new;
  logic [IDX_W-1:0]     nb_idx;
  logic [IDX_W-1:0]     row_idx;
  logic [IDX_W-1:0]     tgt_idx;
  logic [IDX_W-1:0]     src_idx;
  logic [IDX_W-1:0]     qd_idx;
  logic [IDX_W-1:0]     pp_idx;
  row_t                 row_wr;

  assign row_idx = in_row_chart[IDX_W-1:0];
  assign tgt_idx = tgt_r[IDX_W-1:0];
  assign src_idx = src_r[IDX_W-1:0];
  assign qd_idx  = qdata_r[IDX_W-1:0];
  assign pp_idx  = pred_rd_r[IDX_W-1:0];
  assign row_ok  = ({1'b0, in_row_chart} < LIMIT);

  assign row_wr.cnt    = in_nbr_count;
  assign row_wr.nbr[0] = in_nbr_first;
  assign row_wr.nbr[1] = in_nbr_second;
  assign row_wr.nbr[2] = in_nbr_third;

  assign cnt_eff = rdvld_r ? row_r.cnt : '0;
  assign nb      = row_r.nbr[k_r];
  assign nb_idx  = nb[IDX_W-1:0];
  assign nb_new  = ({1'b0, nb} < LIMIT) && !visited_r[nb_idx];

  assign sts.bad_query  = !({1'b0, src_r} < LIMIT) || !({1'b0, tgt_r} < LIMIT);
  assign sts.q_empty    = (head_r == tail_r);
  assign sts.cur_is_src = (qdata_r == src_r);
  assign sts.nbr_done   = (k_r == cnt_eff);
  assign sts.pred_end   = pred_rd_r[CHART_W];
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_row && row_ok) row_vld_r[row_idx] <= 1'b1;
      if (cmd.q_init) begin
        visited_r <= MAX_CHARTS'(1) << tgt_idx;
        head_r    <= '0;
        tail_r    <= (IDX_W + 1)'(1);
      end
      if (cmd.pop_take) head_r <= head_r + (IDX_W + 1)'(1);
      if (cmd.nbr_step && nb_new) begin
        visited_r[nb_idx] <= 1'b1;
        tail_r            <= tail_r + (IDX_W + 1)'(1);
      end
      if (cmd.emit_path || cmd.emit_nf) out_valid_r <= 1'b1;
      else if (out_ready)               out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row && row_ok) row_mem_r[row_idx] <= row_wr;

    if (cmd.q_init) begin
      queue_mem_r[0]      <= tgt_r;
      pred_mem_r[tgt_idx] <= {1'b1, {CHART_W{1'b0}}};
    end else if (cmd.nbr_step && nb_new) begin
      queue_mem_r[tail_r[IDX_W-1:0]] <= nb;
      pred_mem_r[nb_idx]             <= {1'b0, cur_r};
    end

    if (cmd.take_query) begin
      src_r <= in_source_chart;
      tgt_r <= in_target_chart;
    end
    if (cmd.pop_rd) qdata_r <= queue_mem_r[head_r[IDX_W-1:0]];
    if (cmd.pop_take) begin
      cur_r   <= qdata_r;
      row_r   <= row_mem_r[qd_idx];
      rdvld_r <= row_vld_r[qd_idx];
      k_r     <= '0;
    end
    if (cmd.nbr_step) k_r <= k_r + CNT_W'(1);
    if (cmd.tr_start) begin
      cur_r     <= src_r;
      pred_rd_r <= pred_mem_r[src_idx];
    end else if (cmd.tr_next) begin
      cur_r     <= pred_rd_r[CHART_W-1:0];
      pred_rd_r <= pred_mem_r[pp_idx];
    end

    if (cmd.emit_path) begin
      path_r  <= cur_r;
      found_r <= 1'b1;
      last_r  <= pred_rd_r[CHART_W];
    end else if (cmd.emit_nf) begin
      path_r  <= '0;
      found_r <= 1'b0;
      last_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_path_chart = path_r;
  assign out_found      = found_r;
  assign out_last       = last_r;

endmodule

/* rtl/bfscp_ctrl.sv */
// Sequencer for loads, the breadth-first search and the path walk.
`timescale 1ns / 1ps

module bfscp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_mode,
  output logic            in_ready,
  output bfscp_pkg::cmd_t cmd,
  input  bfscp_pkg::sts_t sts
);
  import bfscp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_POPW,
    S_NBR,
    S_TRW,
    S_NF
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_QUERY) begin
            cmd.take_query = 1'b1;
            state_nxt      = S_INIT;
          end else begin
            cmd.load_row = 1'b1;
          end
        end
      end
      S_INIT: begin
        if (sts.bad_query) begin
          state_nxt = S_NF;
        end else begin
          cmd.q_init = 1'b1;
          state_nxt  = S_POP;
        end
      end
      S_POP: begin
        if (sts.q_empty) begin
          state_nxt = S_NF;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POPW;
        end
      end
      S_POPW: begin
        if (sts.cur_is_src) begin
          cmd.tr_start = 1'b1;
          state_nxt    = S_TRW;
        end else begin
          cmd.pop_take = 1'b1;
          state_nxt    = S_NBR;
        end
      end
      S_NBR: begin
        if (sts.nbr_done) state_nxt = S_POP;
        else              cmd.nbr_step = 1'b1;
      end
      S_TRW: begin
        if (sts.out_free) begin
          cmd.emit_path = 1'b1;
          if (sts.pred_end) state_nxt = S_IDLE;
          else              cmd.tr_next = 1'b1;
        end
      end
      S_NF: begin
        if (sts.out_free) begin
          cmd.emit_nf = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
